/* rtl/bhq_pkg.sv */
// Shared constants, codes and types for the binned histogram block.
package bhq_pkg;

	localparam int CNT_W        = 31;
	localparam int VAL_W        = 32;
	localparam int WID_W        = 16;
	localparam int NB_W         = 11;
	localparam int CFG_IDX_W    = 2;
	localparam int MAX_BINS_DEF = 1024;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [1:0] {
		ACT_ADD = 2'd0,
		ACT_BIN = 2'd1,
		ACT_CUM = 2'd2
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RANGE_LOW  = 2'd0,
		REG_RANGE_HIGH = 2'd1,
		REG_BIN_WIDTH  = 2'd2,
		REG_NUM_BINS   = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_PREP,
		S_CHECK,
		S_DIV,
		S_READ,
		S_UPD,
		S_SUM,
		S_SUMW,
		S_DONE
	} state_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (c == CNT_MAX) ? c : c + 1'b1;
	endfunction

endpackage

/* rtl/bhq_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module bhq_ram #(
	parameter int WIDTH = bhq_pkg::CNT_W,
	parameter int DEPTH = bhq_pkg::MAX_BINS_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/bhq_div.sv */
// Restoring divider, one quotient bit per cycle, for dividends below 2^QW times the divisor.
module bhq_div #(
	parameter int DW = $clog2(bhq_pkg::MAX_BINS_DEF + 1) + bhq_pkg::WID_W,
	parameter int QW = $clog2(bhq_pkg::MAX_BINS_DEF)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [DW-1:0]              dividend,
	input  logic [bhq_pkg::WID_W-1:0]  divisor,
	output logic                       done,
	output logic [QW-1:0]              quotient
);

	localparam int CW = $clog2(QW + 1);

	logic [DW-1:0] rem_q;
	logic [DW-1:0] dsr_q;
	logic [QW-1:0] quot_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic          fits;

	assign fits     = (rem_q >= dsr_q);
	assign done     = done_q;
	assign quotient = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsr_q <= DW'(divisor) << (QW - 1);
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsr_q;
			end
			quot_q <= {quot_q[QW-2:0], fits};
			dsr_q  <= dsr_q >> 1;
		end
	end

endmodule

/* rtl/binned_histogram_with_queries.sv */
// Binned histogram with bin-count and cumulative queries. One request is taken at a time:
// after reset a clearing pass writes the MAX_BINS bin counters (1024 by default) to zero
// with in_stall high. For an add or a bin-count query the bin index comes from an
// iterative divider that yields one quotient bit per cycle, skipped when the sample lies
// below range_low or past the end of the last bin, followed by one read of the bin RAM
// and, for an add, one write-back. A cumulative query walks the bin RAM one entry per
// cycle, from entry 0 up to the bin index, in place of the single read. The result sits
// in an output register; the next request is taken as soon as it is loaded.
module binned_histogram_with_queries #(
	parameter int MAX_BINS = bhq_pkg::MAX_BINS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       action,
	input  logic signed [bhq_pkg::VAL_W-1:0] sample_value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [bhq_pkg::CNT_W-1:0]        count,
	output logic [bhq_pkg::CNT_W-1:0]        total_count,
	input  logic                             cfg_wr_en,
	input  logic [bhq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bhq_pkg::VAL_W-1:0]        cfg_data
);

	localparam int IW = $clog2(MAX_BINS);
	localparam int BW = $clog2(MAX_BINS + 1);
	localparam int LW = BW + bhq_pkg::WID_W;
	localparam int VW = bhq_pkg::VAL_W;
	localparam int CW = bhq_pkg::CNT_W;

	// configuration
	logic signed [VW-1:0]          range_low_q;
	logic signed [VW-1:0]          range_high_q;
	logic [bhq_pkg::WID_W-1:0]     bin_width_q;
	logic [bhq_pkg::NB_W-1:0]      num_bins_q;
	logic [bhq_pkg::WID_W-1:0]     w_eff;
	logic [BW-1:0]                 bins_eff;

	// control
	bhq_pkg::state_t               state_q, state_d;
	logic [IW-1:0]                 clr_q;
	logic [IW-1:0]                 ptr_q;
	logic [IW-1:0]                 idx_q;
	logic                          pend_s1;
	logic                          out_valid_q;
	logic                          out_free;

	// request data
	bhq_pkg::action_t              act_q;
	logic signed [VW:0]            diff_q;
	logic                          qok_q;
	logic [LW-1:0]                 limit_q;
	logic [CW-1:0]                 acc_q;
	logic [CW-1:0]                 total_q;
	logic [CW-1:0]                 count_q;
	logic [CW-1:0]                 total_count_q;

	// check stage
	logic [VW:0]                   neg_mag;
	logic                          over_limit;
	logic                          chk_hit;
	logic                          chk_div;
	logic [IW-1:0]                 chk_idx;
	logic [VW:0]                   sum_ext;

	// RAM and divider
	logic                          ram_we;
	logic [IW-1:0]                 ram_waddr;
	logic [CW-1:0]                 ram_wdata;
	logic [IW-1:0]                 ram_raddr;
	logic [CW-1:0]                 ram_rdata;
	logic                          div_start;
	logic                          div_done;
	logic [IW-1:0]                 div_quot;

	assign w_eff = (bin_width_q == '0) ? bhq_pkg::WID_W'(1) : bin_width_q;

	always_comb begin
		if (32'(num_bins_q) > 32'(MAX_BINS)) begin
			bins_eff = BW'(MAX_BINS);
		end else begin
			bins_eff = BW'(num_bins_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= '0;
			range_high_q <= '0;
			bin_width_q  <= bhq_pkg::WID_W'(1);
			num_bins_q   <= bhq_pkg::NB_W'(128);
		end else if (cfg_wr_en) begin
			unique case (bhq_pkg::reg_idx_t'(cfg_index))
				bhq_pkg::REG_RANGE_LOW:  range_low_q  <= cfg_data;
				bhq_pkg::REG_RANGE_HIGH: range_high_q <= cfg_data;
				bhq_pkg::REG_BIN_WIDTH:  bin_width_q  <= cfg_data[bhq_pkg::WID_W-1:0];
				bhq_pkg::REG_NUM_BINS:   num_bins_q   <= cfg_data[bhq_pkg::NB_W-1:0];
				default: ;
			endcase
		end
	end

	// Index decision once the offset and the bins*width limit are registered.
	assign neg_mag    = ~diff_q + 1'b1;
	assign over_limit = !diff_q[VW] && (diff_q[VW-1:0] >= VW'(limit_q));

	always_comb begin
		chk_hit = 1'b0;
		chk_div = 1'b0;
		chk_idx = '0;
		unique case (act_q) inside
			bhq_pkg::ACT_ADD: begin
				if (diff_q[VW]) begin
					// just below range_low truncates into the first bin
					chk_hit = (neg_mag < (VW + 1)'(w_eff)) && (bins_eff != '0);
				end else if (!over_limit) begin
					chk_div = 1'b1;
				end
			end
			bhq_pkg::ACT_BIN, bhq_pkg::ACT_CUM: begin
				if (qok_q) begin
					if (over_limit) begin
						chk_hit = 1'b1;
						chk_idx = IW'(bins_eff - BW'(1));
					end else begin
						chk_div = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	assign out_free = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bhq_pkg::S_CLEAR: begin
				if (clr_q == IW'(MAX_BINS - 1)) state_d = bhq_pkg::S_IDLE;
			end
			bhq_pkg::S_IDLE: begin
				if (in_valid) state_d = bhq_pkg::S_PREP;
			end
			bhq_pkg::S_PREP: state_d = bhq_pkg::S_CHECK;
			bhq_pkg::S_CHECK: begin
				if (chk_div) begin
					state_d = bhq_pkg::S_DIV;
				end else if (chk_hit) begin
					state_d = (act_q == bhq_pkg::ACT_CUM) ? bhq_pkg::S_SUM : bhq_pkg::S_READ;
				end else begin
					state_d = bhq_pkg::S_DONE;
				end
			end
			bhq_pkg::S_DIV: begin
				if (div_done) begin
					state_d = (act_q == bhq_pkg::ACT_CUM) ? bhq_pkg::S_SUM : bhq_pkg::S_READ;
				end
			end
			bhq_pkg::S_READ: state_d = bhq_pkg::S_UPD;
			bhq_pkg::S_UPD:  state_d = bhq_pkg::S_DONE;
			bhq_pkg::S_SUM: begin
				if (ptr_q == idx_q) state_d = bhq_pkg::S_SUMW;
			end
			bhq_pkg::S_SUMW: state_d = bhq_pkg::S_DONE;
			bhq_pkg::S_DONE: begin
				if (out_free) state_d = bhq_pkg::S_IDLE;
			end
			default: state_d = bhq_pkg::S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_stall  = (state_q != bhq_pkg::S_IDLE);
		div_start = (state_q == bhq_pkg::S_CHECK) && chk_div;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = bhq_pkg::sat_inc(ram_rdata);
		ram_raddr = idx_q;
		unique case (state_q)
			bhq_pkg::S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			bhq_pkg::S_UPD: begin
				ram_we = (act_q == bhq_pkg::ACT_ADD);
			end
			bhq_pkg::S_SUM: begin
				ram_raddr = ptr_q;
			end
			default: ;
		endcase
	end

	assign sum_ext = (VW + 1)'(acc_q) + (VW + 1)'(ram_rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bhq_pkg::S_CLEAR;
			clr_q       <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			total_q     <= '0;
		end else begin
			state_q <= state_d;
			pend_s1 <= (state_q == bhq_pkg::S_SUM);
			if (state_q == bhq_pkg::S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if ((state_q == bhq_pkg::S_UPD) && (act_q == bhq_pkg::ACT_ADD)) begin
				total_q <= bhq_pkg::sat_inc(total_q);
			end
			if ((state_q == bhq_pkg::S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			bhq_pkg::S_IDLE: begin
				act_q  <= bhq_pkg::action_t'(action);
				diff_q <= (VW + 1)'(sample_value) - (VW + 1)'(range_low_q);
				qok_q  <= (bins_eff != '0) && (sample_value >= range_low_q)
					&& (sample_value <= range_high_q);
				acc_q  <= '0;
			end
			bhq_pkg::S_PREP: begin
				limit_q <= LW'(bins_eff) * LW'(w_eff);
			end
			bhq_pkg::S_CHECK: begin
				idx_q <= chk_idx;
				ptr_q <= '0;
			end
			bhq_pkg::S_DIV: begin
				if (div_done) idx_q <= div_quot;
			end
			bhq_pkg::S_UPD: begin
				if (act_q == bhq_pkg::ACT_BIN) acc_q <= ram_rdata;
			end
			bhq_pkg::S_SUM: begin
				ptr_q <= ptr_q + 1'b1;
			end
			bhq_pkg::S_DONE: begin
				if (out_free) begin
					count_q       <= acc_q;
					total_count_q <= total_q;
				end
			end
			default: ;
		endcase
		// cumulative walk: data arrives in the cycle after each address
		if (pend_s1) begin
			acc_q <= sum_ext[VW-1:0] > VW'(bhq_pkg::CNT_MAX) ? bhq_pkg::CNT_MAX
				: sum_ext[CW-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign count       = count_q;
	assign total_count = total_count_q;

	bhq_ram #(
		.WIDTH(CW),
		.DEPTH(MAX_BINS)
	) u_bins (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	bhq_div #(
		.DW(LW),
		.QW(IW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (diff_q[LW-1:0]),
		.divisor  (w_eff),
		.done     (div_done),
		.quotient (div_quot)
	);

endmodule
